// File: src/dsis_pkg.sv
// ============================================================================
// dsis_pkg
// Shared types and constants for the distinct sorted index sampler.
// ============================================================================
package dsis_pkg;

    localparam int MaxSamples = 64;

    localparam logic [63:0] GoldenStep = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MixMulA    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MixMulB    = 64'h94D049BB133111EB;

    typedef struct packed {
        logic [63:0] seed;
        logic [31:0] chunk_total;
        logic [6:0]  pick_target;
    } t_req;

    typedef struct packed {
        logic [31:0] chunk_index;
        logic        last;
    } t_rsp;

    typedef enum logic [1:0] {
        CMD_SEQ,
        CMD_RAND
    } t_cmd_kind;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [63:0] seed;
        logic [31:0] chunks;
        logic [6:0]  wanted;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEQ,
        ST_MIX0,
        ST_MUL,
        ST_MIX1,
        ST_MIX2,
        ST_DIV,
        ST_SCAN,
        ST_OUT_RD,
        ST_OUT
    } t_state;

endpackage

// File: src/dsis_front.sv
// ============================================================================
// dsis_front
// Accepts requests, saturates the sample count, drops empty requests and
// queues classified commands for the back end.
// ============================================================================
module dsis_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dsis_pkg::t_req  i_req,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output dsis_pkg::t_cmd  o_cmd
);
    import dsis_pkg::*;

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_cmd        w_cmd;
    logic [6:0]  w_wanted;
    logic        w_push;
    logic        w_pop;
    logic        w_keep;

    always_comb begin
        w_wanted = (i_req.pick_target > 7'(MaxSamples)) ? 7'(MaxSamples)
                                                       : i_req.pick_target;
        w_keep = (i_req.chunk_total != 32'd0) && (w_wanted != 7'd0);
        w_cmd.seed   = i_req.seed;
        w_cmd.chunks = i_req.chunk_total;
        w_cmd.wanted = w_wanted;
        w_cmd.kind   = ({25'd0, w_wanted} >= i_req.chunk_total) ? CMD_SEQ : CMD_RAND;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready && w_keep;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// File: src/dsis_divider.sv
// ============================================================================
// dsis_divider
// Restoring 64-by-32 remainder unit, one quotient bit per cycle.
// ============================================================================
module dsis_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [63:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic [33:0] w_diff;

    assign w_sh   = {r_rem[31:0], r_num[63]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_div};
    assign o_rem  = r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= 33'd0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            if (!w_diff[33]) begin
                r_rem <= w_diff[32:0];
            end else begin
                r_rem <= w_sh;
            end
        end
    end

endmodule

// File: src/dsis_back.sv
// ============================================================================
// dsis_back
// Runs one command: either counts out 0..n-1 or steps the generator, reduces
// each draw and keeps a sorted distinct list in a memory, then streams it.
// ============================================================================
module dsis_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  dsis_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output dsis_pkg::t_rsp  o_rsp
);
    import dsis_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [63:0] r_mixer;
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [1:0]  r_mstep;
    logic        r_mul_b;
    logic [31:0] r_chunks;
    logic [6:0]  r_wanted;
    logic [6:0]  r_picks;
    logic [10:0] r_attempts;
    logic [6:0]  r_pos;
    logic [31:0] r_val;
    logic [31:0] r_carry;
    logic        r_ins;
    logic [31:0] r_seq;
    logic [31:0] r_mem [MaxSamples];
    logic [31:0] r_rd;
    logic        r_ov;
    t_rsp        r_out;

    logic        w_div_done;
    logic [31:0] w_rem;
    logic        w_div_start;
    logic [63:0] w_mix_sum;
    logic [63:0] w_mix_out;
    logic [63:0] w_mul_k;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic        w_out_free;
    logic        w_load;
    logic [10:0] w_limit;
    logic        w_at_end;
    logic        w_dup;
    logic        w_scan_end;
    logic [6:0]  w_picks_next;
    logic        w_more;
    logic [5:0]  w_rd_addr;
    logic        w_we;
    logic [5:0]  w_wr_addr;
    logic [31:0] w_wr_data;

    dsis_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mix_out),
        .i_divisor  (r_chunks),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_out_free = !r_ov || i_ready;
    assign o_valid    = r_ov;
    assign o_rsp      = r_out;
    assign w_limit    = {r_wanted, 4'd0};
    assign w_mix_sum  = r_mixer + GoldenStep;
    assign w_mix_out  = r_acc ^ (r_acc >> 31);

    // The 64-bit products keep only their low half, built from three
    // 32 by 32 partial products taken one per cycle.
    always_comb begin
        w_mul_k = r_mul_b ? MixMulB : MixMulA;
        case (r_mstep)
            2'd0: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_mul_k[31:0];
            end
            2'd1: begin
                w_mul_a = r_z[63:32];
                w_mul_b = w_mul_k[31:0];
            end
            default: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_mul_k[63:32];
            end
        endcase
        w_prod = 64'(w_mul_a) * 64'(w_mul_b);
    end

    // Scan: r_rd holds entry r_pos. Past the insertion point the old entries
    // ripple up one slot, each carried through r_carry.
    assign w_at_end     = (r_pos == r_picks);
    assign w_dup        = !w_at_end && !r_ins && (r_rd == r_val);
    assign w_scan_end   = (r_state == ST_SCAN) && (w_at_end || w_dup);
    assign w_picks_next = r_picks + {6'd0, w_at_end};
    assign w_more       = (w_picks_next < r_wanted) && (r_attempts < w_limit);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == CMD_SEQ) ? ST_SEQ : ST_MIX0;
                end
            end
            ST_SEQ: begin
                if (w_out_free && (r_seq + 32'd1 == r_chunks)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MIX0: n_state = ST_MUL;
            ST_MUL: begin
                if (r_mstep == 2'd2) begin
                    n_state = r_mul_b ? ST_MIX2 : ST_MIX1;
                end
            end
            ST_MIX1: n_state = ST_MUL;
            ST_MIX2: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = w_more ? ST_MIX0 : ST_OUT_RD;
                end
            end
            ST_OUT_RD: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = (r_pos + 7'd1 == r_picks) ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and memory control.
    always_comb begin
        o_cmd_ready = (r_state == ST_IDLE);
        w_div_start = (r_state == ST_MIX2);
        w_load      = w_out_free && (r_state == ST_SEQ || r_state == ST_OUT);
        w_we        = 1'b0;
        w_wr_addr   = r_pos[5:0];
        w_wr_data   = r_val;
        w_rd_addr   = r_pos[5:0];
        case (r_state)
            ST_DIV: begin
                w_rd_addr = 6'd0;
            end
            ST_SCAN: begin
                w_rd_addr = 6'(r_pos + 7'd1);
                w_wr_data = r_ins ? r_carry : r_val;
                if (w_at_end || r_ins || r_rd > r_val) begin
                    w_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mixer    <= 64'd0;
            r_picks    <= 7'd0;
            r_attempts <= 11'd0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_chunks <= i_cmd.chunks;
                    r_wanted <= i_cmd.wanted;
                    r_seq    <= 32'd0;
                    if (i_cmd_valid && i_cmd.kind == CMD_RAND) begin
                        r_mixer    <= i_cmd.seed;
                        r_picks    <= 7'd0;
                        r_attempts <= 11'd0;
                    end
                end
                ST_SEQ: begin
                    if (w_out_free) begin
                        r_out.chunk_index <= r_seq;
                        r_out.last        <= (r_seq + 32'd1 == r_chunks);
                        r_seq             <= r_seq + 32'd1;
                    end
                end
                ST_MIX0: begin
                    r_mixer    <= w_mix_sum;
                    r_z        <= w_mix_sum ^ (w_mix_sum >> 30);
                    r_attempts <= r_attempts + 11'd1;
                    r_mstep    <= 2'd0;
                    r_mul_b    <= 1'b0;
                end
                ST_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd0) begin
                        r_acc <= w_prod;
                    end else begin
                        r_acc <= r_acc + {w_prod[31:0], 32'd0};
                    end
                end
                ST_MIX1: begin
                    r_z     <= r_acc ^ (r_acc >> 27);
                    r_mstep <= 2'd0;
                    r_mul_b <= 1'b1;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_val <= w_rem;
                        r_pos <= 7'd0;
                        r_ins <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (w_scan_end) begin
                        r_pos <= 7'd0;
                        if (w_at_end) begin
                            r_picks <= r_picks + 7'd1;
                        end
                    end else begin
                        r_pos <= r_pos + 7'd1;
                        if (r_ins || r_rd > r_val) begin
                            r_ins   <= 1'b1;
                            r_carry <= r_rd;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out.chunk_index <= r_rd;
                        r_out.last        <= (r_pos + 7'd1 == r_picks);
                        r_pos             <= r_pos + 7'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/distinct_sorted_index_sampler.sv
// ============================================================================
// distinct_sorted_index_sampler
// Draws a sorted run of distinct chunk indices from a splitmix64 stream.
// ============================================================================
//  channel   signals                     word
//  request   i_valid / o_ready / i_req   seed, chunk_total, pick_target
//  result    o_valid / i_ready / o_rsp   chunk_index, last
//
// A covering request emits one index per cycle while the result side is
// ready. A sampled request runs, per attempt, the mixer (each 64-bit multiply
// built from three partial products), the serial remainder and a scan of the
// list. Up to 16 attempts per wanted index; each index is then read in
// ST_OUT_RD and sent in ST_OUT. Reset is synchronous; a stalled result holds
// the back end, and a two-entry queue lets the front keep accepting.
module distinct_sorted_index_sampler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dsis_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output dsis_pkg::t_rsp  o_rsp
);
    import dsis_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    dsis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    dsis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// File: sim/distinct_sorted_index_sampler_tb.sv
// ============================================================================
// distinct_sorted_index_sampler_tb
// Checks the sampler word by word against a splitmix64 predictor. It runs a
// directed table, then random requests, with random idling on both sides and
// one long stall on the result side.
// ============================================================================
module distinct_sorted_index_sampler_tb;
    import dsis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SampleCap = 64;
    localparam logic [63:0] GoldenInc = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MulA      = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MulB      = 64'h94D049BB133111EB;
    localparam int          CycleLimit = 60000000;
    localparam int          LongHold   = 3000;
    localparam int          RandItems  = 275;

    // A typed-in expectation: n >= 0 means the run is 0 .. n-1, -1 means
    // the predictor decides.
    typedef struct {
        t_req req;
        int   n;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_rsp  o_rsp;

    t_rsp        expected_words[$];
    logic [63:0] gen_word;
    int          errors = 0;
    int          cycles = 0;
    int          cur_typed_n;
    bit          sender_done;
    bit          hold_request;
    bit          quiet;

    distinct_sorted_index_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input t_rsp got, input t_rsp want);
        $display("mismatch %s: got index %0d last %0b, want index %0d last %0b",
                 what, got.chunk_index, got.last, want.chunk_index, want.last);
        errors++;
    endtask

    function automatic void push_covering_run(input logic [31:0] n);
        t_rsp w;
        for (logic [32:0] i = 0; i < n; i++) begin
            w.chunk_index = i[31:0];
            w.last        = (i + 1 == n);
            expected_words.push_back(w);
        end
    endfunction

    function automatic logic [63:0] mix_next();
        logic [63:0] z;
        gen_word = gen_word + GoldenInc;
        z = gen_word;
        z = (z ^ (z >> 30)) * MulA;
        z = (z ^ (z >> 27)) * MulB;
        return z ^ (z >> 31);
    endfunction

    function automatic void predict_indices(input t_req r);
        int          wanted;
        int          budget;
        int          pos;
        logic [31:0] v;
        logic [31:0] picks[$];
        t_rsp        w;
        wanted = r.pick_target;
        if (wanted > SampleCap) wanted = SampleCap;
        if (r.chunk_total == 0 || wanted == 0) return;
        if (wanted >= r.chunk_total) begin
            push_covering_run(r.chunk_total);
            return;
        end
        gen_word = r.seed;
        budget = wanted * 16;
        for (int a = 0; a < budget && picks.size() < wanted; a++) begin
            v = 32'(mix_next() % {32'b0, r.chunk_total});
            pos = 0;
            while (pos < picks.size() && picks[pos] < v) pos++;
            if (!(pos < picks.size() && picks[pos] == v) && picks.size() < SampleCap)
                picks.insert(pos, v);
        end
        foreach (picks[i]) begin
            w.chunk_index = picks[i];
            w.last        = (i == picks.size() - 1);
            expected_words.push_back(w);
        end
    endfunction

    // Both handshakes are sampled here; the block updates on nonblocking
    // assignments, so these reads see the values before the edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && o_ready) begin
            if (cur_typed_n >= 0) push_covering_run(cur_typed_n);
            else predict_indices(i_req);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", o_rsp, '0);
            end else begin
                if (o_rsp.chunk_index !== expected_words[0].chunk_index)
                    report("chunk_index", o_rsp, expected_words[0]);
                else if (o_rsp.last !== expected_words[0].last)
                    report("last", o_rsp, expected_words[0]);
                void'(expected_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("distinct_sorted_index_sampler_tb: FAIL");
            $finish;
        end
    end

    task automatic send_request(input t_req r, input int typed_n);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req       = r;
        cur_typed_n = typed_n;
        i_valid     = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic t_req make_req(input logic [63:0] s, input logic [31:0] c,
                                      input logic [6:0] n);
        t_req r;
        r.seed = s;
        r.chunk_total = c;
        r.pick_target = n;
        return r;
    endfunction

    function automatic t_req random_req();
        int          kind;
        int          n;
        logic [63:0] s;
        logic [31:0] c;
        kind = $urandom_range(0, 99);
        s = {$urandom, $urandom};
        if (kind < 10) begin
            n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 127);
            c = (n == 0) ? $urandom : 0;
        end else if (kind < 30) begin
            n = $urandom_range(1, 64);
            if ($urandom_range(0, 3) != 0) n = $urandom_range(1, 8);
            c = $urandom_range(1, n);
        end else if (kind < 80) begin
            n = $urandom_range(1, 8);
            c = $urandom_range(0, 1) ? $urandom_range(n + 1, n + 20) : $urandom;
            if (c <= n) c = n + 1;
        end else if (kind < 92) begin
            // One chunk beyond the wanted count: the attempt budget may run out.
            n = $urandom_range(2, 6);
            c = n + 1;
        end else begin
            n = $urandom_range(65, 127);
            c = $urandom_range(0, 3) ? $urandom_range(1, 64) : $urandom;
            if (c == 0) c = 1;
        end
        return make_req(s, c, 7'(n));
    endfunction

    // Sender.
    initial begin
        t_row table_rows[$];
        sender_done  = 1'b0;
        hold_request = 1'b0;
        quiet        = 1'b0;
        cur_typed_n  = -1;
        i_valid      = 1'b0;
        i_req        = '0;
        i_rst_n      = 1'b0;
        table_rows.push_back('{make_req(64'h0, 32'd0, 7'd5), 0});
        table_rows.push_back('{make_req({64{1'b1}}, 32'd10, 7'd0), 0});
        table_rows.push_back('{make_req(64'h0, 32'd0, 7'd64), 0});
        table_rows.push_back('{make_req(64'h1, 32'd1, 7'd1), 1});
        table_rows.push_back('{make_req(64'h2, 32'd64, 7'd64), 64});
        table_rows.push_back('{make_req(64'h3, 32'd3, 7'd127), 3});
        table_rows.push_back('{make_req(64'h4, 32'd64, 7'd65), 64});
        table_rows.push_back('{make_req(64'h0, 32'hFFFFFFFF, 7'd1), -1});
        table_rows.push_back('{make_req({64{1'b1}}, 32'hFFFFFFFF, 7'd64), -1});
        table_rows.push_back('{make_req(64'h0123456789ABCDEF, 32'd2, 7'd1), -1});
        table_rows.push_back('{make_req(64'hFEDCBA9876543210, 32'd100, 7'd127), -1});
        table_rows.push_back('{make_req(64'h0, 32'd5, 7'd4), -1});
        table_rows.push_back('{make_req(64'h5555AAAA5555AAAA, 32'd65, 7'd64), -1});
        table_rows.push_back('{make_req(64'hAAAA5555AAAA5555, 32'd3, 7'd2), -1});
        table_rows.push_back('{make_req(64'h8000000000000000, 32'h80000000, 7'd8), -1});
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].n);
        hold_request = 1'b1;
        for (int k = 0; k < RandItems; k++) begin
            quiet = (k >= 120 && k < 150);
            send_request(random_req(), -1);
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        sender_done = 1'b1;
    end

    // Receiver.
    initial begin
        int gap;
        bit held_off;
        held_off = 1'b0;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request && !held_off) begin
                held_off = 1'b1;
                i_ready = 1'b0;
                repeat (LongHold) @(negedge i_clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        wait (sender_done);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("distinct_sorted_index_sampler_tb: PASS");
        end else begin
            $display("distinct_sorted_index_sampler_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: distinct_sorted_index_sampler.f
src/dsis_pkg.sv
src/dsis_front.sv
src/dsis_divider.sv
src/dsis_back.sv
src/distinct_sorted_index_sampler.sv
sim/distinct_sorted_index_sampler_tb.sv
